>>> hw/rtl/arpr_pkg.sv
// ----------------------------------------------------------------------------
// arpr_pkg: shared types and constants for the ARM PC-relative relocator
// Instruction classes, replacement opcodes and the record that travels from
// the classifier to the word sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package arpr_pkg;

  // Default size of the hook stub in bytes
  localparam int unsigned STUB_BYTES_DEFAULT = 8;

  // Entries in the queue between classifier and sequencer
  localparam int unsigned QUEUE_DEPTH = 2;

  // Replacement opcodes
  localparam logic [31:0] OP_ADD_LR_PC4  = 32'hE28FE004;
  localparam logic [31:0] OP_LDR_PC_PCM4 = 32'hE51FF004;
  localparam logic [31:0] OP_PUSH_R      = 32'hE52D0004;
  localparam logic [31:0] OP_LDR_R_PC8   = 32'hE59F0008;
  localparam logic [31:0] OP_POP_R       = 32'hE49D0004;
  localparam logic [31:0] OP_ADD_PC_PC   = 32'hE28FF000;
  localparam logic [31:0] OP_LDR_R_PC    = 32'hE51F0000;

  // Classification masks and patterns
  localparam logic [31:0] MASK_BLX = 32'hFE000000;
  localparam logic [31:0] PAT_BLX  = 32'hFA000000;
  localparam logic [31:0] MASK_BR  = 32'h0F000000;
  localparam logic [31:0] PAT_BL   = 32'h0B000000;
  localparam logic [31:0] PAT_B    = 32'h0A000000;
  localparam logic [31:0] MASK_BX  = 32'h0FF000FF;
  localparam logic [31:0] PAT_BX   = 32'h0120001F;
  localparam logic [31:0] MASK_ADD = 32'h0FEF0010;
  localparam logic [31:0] PAT_ADD  = 32'h008F0000;
  localparam logic [31:0] MASK_ADR = 32'h0FFF0000;
  localparam logic [31:0] PAT_ADRA = 32'h028F0000;
  localparam logic [31:0] PAT_ADRS = 32'h024F0000;
  localparam logic [31:0] MASK_LDR = 32'h0E5F0000;
  localparam logic [31:0] PAT_LDR  = 32'h041F0000;
  localparam logic [31:0] MASK_MOV = 32'h0FE00FFF;
  localparam logic [31:0] PAT_MOV  = 32'h01A0000F;

  // Register file offsets of the configuration port (word index)
  localparam logic REG_STUB_BASE = 1'b0;

  // Instruction classes
  typedef enum logic [3:0] {
    CLS_BLX     = 4'd0,
    CLS_BL      = 4'd1,
    CLS_B       = 4'd2,
    CLS_BX      = 4'd3,
    CLS_ADD     = 4'd4,
    CLS_ADR_ADD = 4'd5,
    CLS_ADR_SUB = 4'd6,
    CLS_LDR     = 4'd7,
    CLS_MOV     = 4'd8,
    CLS_OTHER   = 4'd9
  } cls_t;

  // One classified item, as queued for the sequencer
  typedef struct packed {
    logic        close;  // jump back to the stub end
    cls_t        cls;
    logic [31:0] word;   // original word, Rn already swapped for ADD
    logic [31:0] value;  // target, pc or literal data word
    logic [3:0]  rs;     // scratch register for ADD
    logic [2:0]  count;  // words to emit, 1 to 6
  } item_t;

endpackage

`default_nettype wire

>>> hw/rtl/arpr_front.sv
// ----------------------------------------------------------------------------
// arpr_front: classifier and address unit
// Decodes each instruction, works out its PC-relative value in one three-input
// add and keeps the running instruction index.
// ----------------------------------------------------------------------------
`default_nettype none

module arpr_front #(
  parameter int unsigned STUB_BYTES = arpr_pkg::STUB_BYTES_DEFAULT
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 accept,
  input  wire                 cmd,
  input  wire  [31:0]         instruction_word,
  input  wire  [31:0]         literal_word,
  input  wire  [31:0]         base,
  output arpr_pkg::item_t     item
);

  logic [5:0]  index;
  arpr_pkg::cls_t cls;
  logic [3:0]  rd;
  logic [3:0]  rm;
  logic [3:0]  rs;
  logic [8:0]  pc_ofs;
  logic [31:0] addend_b;
  logic [31:0] addend_c;
  logic        carry_in;
  logic [31:0] sum;
  logic [31:0] value;
  logic [31:0] word;
  logic [2:0]  count;

  // Classify the word
  always_comb begin
    if ((instruction_word & arpr_pkg::MASK_BLX) == arpr_pkg::PAT_BLX) begin
      cls = arpr_pkg::CLS_BLX;
    end else if ((instruction_word & arpr_pkg::MASK_BR) == arpr_pkg::PAT_BL) begin
      cls = arpr_pkg::CLS_BL;
    end else if ((instruction_word & arpr_pkg::MASK_BR) == arpr_pkg::PAT_B) begin
      cls = arpr_pkg::CLS_B;
    end else if ((instruction_word & arpr_pkg::MASK_BX) == arpr_pkg::PAT_BX) begin
      cls = arpr_pkg::CLS_BX;
    end else if ((instruction_word & arpr_pkg::MASK_ADD) == arpr_pkg::PAT_ADD) begin
      cls = arpr_pkg::CLS_ADD;
    end else if ((instruction_word & arpr_pkg::MASK_ADR) == arpr_pkg::PAT_ADRA) begin
      cls = arpr_pkg::CLS_ADR_ADD;
    end else if ((instruction_word & arpr_pkg::MASK_ADR) == arpr_pkg::PAT_ADRS) begin
      cls = arpr_pkg::CLS_ADR_SUB;
    end else if ((instruction_word & arpr_pkg::MASK_LDR) == arpr_pkg::PAT_LDR) begin
      cls = arpr_pkg::CLS_LDR;
    end else if ((instruction_word & arpr_pkg::MASK_MOV) == arpr_pkg::PAT_MOV) begin
      cls = arpr_pkg::CLS_MOV;
    end else begin
      cls = arpr_pkg::CLS_OTHER;
    end
  end

  // Pick a scratch register counting down from r12, avoiding Rd and Rm
  assign rd = instruction_word[15:12];
  assign rm = instruction_word[3:0];
  always_comb begin
    rs = 4'd12;
    if (rd == 4'd12 || rm == 4'd12) begin
      rs = 4'd11;
      if (rd == 4'd11 || rm == 4'd11) begin
        rs = 4'd10;
      end
    end
  end

  // Offset of this instruction's PC from the base: 8 + 4 * index
  assign pc_ofs = {1'b0, index, 2'b00} + 9'd8;

  // Select the add operands: base + pc offset (stub size on close) + branch or
  // immediate offset, with the carry giving the Thumb bit for BLX and the negate for ADR sub
  always_comb begin
    addend_b = {23'd0, pc_ofs};
    addend_c = '0;
    carry_in = 1'b0;
    word     = instruction_word;
    count    = 3'd1;
    if (cmd) begin
      addend_b = 32'(STUB_BYTES);
      count    = 3'd2;
    end else begin
      case (cls)
        arpr_pkg::CLS_BLX: begin
          addend_c = {{6{instruction_word[23]}}, instruction_word[23:0],
                      instruction_word[24], 1'b0};
          carry_in = 1'b1;
          count    = 3'd3;
        end
        arpr_pkg::CLS_BL: begin
          addend_c = {{6{instruction_word[23]}}, instruction_word[23:0], 2'b00};
          count    = 3'd3;
        end
        arpr_pkg::CLS_B: begin
          addend_c = {{6{instruction_word[23]}}, instruction_word[23:0], 2'b00};
          count    = 3'd2;
        end
        arpr_pkg::CLS_BX: begin
          count = 3'd2;
        end
        arpr_pkg::CLS_ADD: begin
          word  = {instruction_word[31:20], rs, instruction_word[15:0]};
          count = 3'd6;
        end
        arpr_pkg::CLS_ADR_ADD: begin
          addend_c = {20'd0, instruction_word[11:0]};
          count    = 3'd3;
        end
        arpr_pkg::CLS_ADR_SUB: begin
          addend_c = ~{20'd0, instruction_word[11:0]};
          carry_in = 1'b1;
          count    = 3'd3;
        end
        arpr_pkg::CLS_LDR, arpr_pkg::CLS_MOV: begin
          count = 3'd3;
        end
        default: begin
          count = 3'd1;
        end
      endcase
    end
  end

  assign sum = base + addend_b + addend_c + {31'd0, carry_in};

  // Final value word: caller's literal for LDR
  always_comb begin
    value = sum;
    if (!cmd && cls == arpr_pkg::CLS_LDR) begin
      value = literal_word;
    end
  end

  assign item.close = cmd;
  assign item.cls   = cmd ? arpr_pkg::CLS_OTHER : cls;
  assign item.word  = word;
  assign item.value = value;
  assign item.rs    = rs;
  assign item.count = count;

  // Advance the index per relocated instruction, restart on close
  always_ff @(posedge clk) begin
    if (rst) begin
      index <= '0;
    end else if (accept) begin
      if (cmd) begin
        index <= '0;
      end else begin
        index <= index + 6'd1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/arpr_queue.sv
// ----------------------------------------------------------------------------
// arpr_queue: short item queue
// Holds classified items between the classifier and the word sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module arpr_queue (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  arpr_pkg::item_t  push_item,
  output logic             full,
  input  wire              pop,
  output logic             head_valid,
  output arpr_pkg::item_t  head_item
);

  localparam int unsigned DEPTH   = arpr_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

  arpr_pkg::item_t    entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] fill;

  assign full       = (fill == COUNT_W'(DEPTH));
  assign head_valid = (fill != '0);
  assign head_item  = entries[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/arpr_back.sv
// ----------------------------------------------------------------------------
// arpr_back: word sequencer
// Steps through the replacement sequence of the item at the queue head and
// presents one word per cycle in the output register unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module arpr_back (
  input  wire              clk,
  input  wire              rst,
  input  wire              head_valid,
  input  arpr_pkg::item_t  head_item,
  output logic             pop,
  output logic             result_valid,
  input  wire              result_ready,
  output logic [31:0]      output_word,
  output logic [3:0]       instruction_class,
  output logic             last
);

  logic [2:0]  step;
  logic        load;
  logic        final_word;
  logic [31:0] word_sel;
  logic [3:0]  rd;

  assign rd         = head_item.word[15:12];
  assign load       = head_valid && (!result_valid || result_ready);
  assign final_word = (step == head_item.count - 3'd1);
  assign pop        = load && final_word;

  // Select the word for the current step
  always_comb begin
    word_sel = head_item.value;
    if (head_item.close) begin
      if (step == 3'd0) begin
        word_sel = arpr_pkg::OP_LDR_PC_PCM4;
      end
    end else begin
      unique case (head_item.cls)
        arpr_pkg::CLS_BLX, arpr_pkg::CLS_BL: begin
          if (step == 3'd0) begin
            word_sel = arpr_pkg::OP_ADD_LR_PC4;
          end else if (step == 3'd1) begin
            word_sel = arpr_pkg::OP_LDR_PC_PCM4;
          end
        end
        arpr_pkg::CLS_B, arpr_pkg::CLS_BX: begin
          if (step == 3'd0) begin
            word_sel = arpr_pkg::OP_LDR_PC_PCM4;
          end
        end
        arpr_pkg::CLS_ADD: begin
          case (step)
            3'd0:    word_sel = arpr_pkg::OP_PUSH_R | {16'd0, head_item.rs, 12'd0};
            3'd1:    word_sel = arpr_pkg::OP_LDR_R_PC8 | {16'd0, head_item.rs, 12'd0};
            3'd2:    word_sel = head_item.word;
            3'd3:    word_sel = arpr_pkg::OP_POP_R | {16'd0, head_item.rs, 12'd0};
            3'd4:    word_sel = arpr_pkg::OP_ADD_PC_PC;
            default: word_sel = head_item.value;
          endcase
        end
        arpr_pkg::CLS_ADR_ADD, arpr_pkg::CLS_ADR_SUB,
        arpr_pkg::CLS_LDR, arpr_pkg::CLS_MOV: begin
          if (step == 3'd0) begin
            word_sel = arpr_pkg::OP_LDR_R_PC | {16'd0, rd, 12'd0};
          end else if (step == 3'd1) begin
            word_sel = arpr_pkg::OP_ADD_PC_PC;
          end
        end
        default: begin
          word_sel = head_item.word;
        end
      endcase
    end
  end

  // Step counter: advance per loaded word, restart at the end of an item
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (load) begin
      step <= final_word ? 3'd0 : step + 3'd1;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      output_word       <= word_sel;
      instruction_class <= head_item.cls;
      last              <= final_word;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/arm_pc_relative_relocator.sv
// ----------------------------------------------------------------------------
// arm_pc_relative_relocator: ARM32 PC-relative instruction relocator
// Rewrites hooked ARM instructions into trampoline word sequences that keep
// their PC-relative meaning, and closes the trampoline with a jump back.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------
//  item     | item_valid / item_ready    | cmd, instruction_word, literal_word
//  result   | result_valid / result_ready| output_word, instruction_class, last
//  config   | APB psel/penable/pwrite    | paddr, pwdata, prdata (stub base)
//
//  One result word leaves per cycle unless the result is stalled; an item
//  has 1 to 6 words from the word sequencer. A two-entry queue lets items be
//  accepted back to back while the sequencer is busy or the result is stalled.
//  Reset (rst, synchronous) clears the index, the queue and the result valid.
//  Classification and the address add settle before the item transfer, so
//  the item is queued complete and its first word then goes to the output
//  register.
`default_nettype none

module arm_pc_relative_relocator #(
  parameter int unsigned STUB_BYTES = arpr_pkg::STUB_BYTES_DEFAULT
) (
  input  wire         clk,
  input  wire         rst,
  // item channel
  input  wire         item_valid,
  output logic        item_ready,
  input  wire         cmd,
  input  wire  [31:0] instruction_word,
  input  wire  [31:0] literal_word,
  // result channel
  output logic        result_valid,
  input  wire         result_ready,
  output logic [31:0] output_word,
  output logic [3:0]  instruction_class,
  output logic        last,
  // configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic            stub_base_address;
  logic [31:0]     base;
  logic            accept;
  logic            full;
  logic            pop;
  logic            head_valid;
  arpr_pkg::item_t front_item;
  arpr_pkg::item_t head_item;

  assign stub_base_address = (paddr[2] == arpr_pkg::REG_STUB_BASE);

  // Configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
    end else if (psel && penable && pwrite && pready && stub_base_address) begin
      base <= pwdata;
    end
  end
  assign prdata = stub_base_address ? base : '0;

  assign item_ready = !full;
  assign accept     = item_valid && item_ready;

  arpr_front #(
    .STUB_BYTES (STUB_BYTES)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .cmd              (cmd),
    .instruction_word (instruction_word),
    .literal_word     (literal_word),
    .base             (base),
    .item             (front_item)
  );

  arpr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_item  (front_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  arpr_back u_back (
    .clk               (clk),
    .rst               (rst),
    .head_valid        (head_valid),
    .head_item         (head_item),
    .pop               (pop),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .output_word       (output_word),
    .instruction_class (instruction_class),
    .last              (last)
  );

endmodule

`default_nettype wire

>>> hw/rtl/arpr_checker.sv
// ----------------------------------------------------------------------------
// arpr_checker: port-level checks for the relocator
// Watches the result channel and configuration port over time.
// ----------------------------------------------------------------------------
`default_nettype none

module arpr_checker (
  input wire        clk,
  input wire        rst,
  input wire        result_valid,
  input wire        result_ready,
  input wire [31:0] output_word,
  input wire [3:0]  instruction_class,
  input wire        last,
  input wire        pready
);

  // No result straight out of reset
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(output_word))
    else $error("stalled result changed");

  // Hold class and last of a stalled result
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(instruction_class) && $stable(last))
    else $error("stalled result class or last changed");

  // Classes stay in the defined range
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> instruction_class <= 4'(arpr_pkg::CLS_OTHER))
    else $error("class out of range");

  // Configuration port never stalls
  assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind arm_pc_relative_relocator arpr_checker u_arpr_checker (
  .clk               (clk),
  .rst               (rst),
  .result_valid      (result_valid),
  .result_ready      (result_ready),
  .output_word       (output_word),
  .instruction_class (instruction_class),
  .last              (last),
  .pready            (pready)
);

`default_nettype wire
